/* hw/rtl/msi_pkg.sv */
package msi_pkg;

   localparam int unsigned SAMPLE_W = 16;
   localparam int unsigned WEIGHT_W = 16;
   localparam int unsigned ACC_W    = 40;
   localparam int unsigned PROD_W   = 33;

   // one in Q2.14, used as the bias activation
   localparam logic [SAMPLE_W-1:0] ONE_Q14 = 16'd16384;

   // activation memory bank codes
   localparam logic [1:0] BANK_SAMPLE = 2'd0;
   localparam logic [1:0] BANK_HID_A  = 2'd1;
   localparam logic [1:0] BANK_HID_B  = 2'd2;

   // request function codes
   localparam logic FUNC_WEIGHT = 1'b0;
   localparam logic FUNC_SAMPLE = 1'b1;

   typedef enum logic [6:0] {
      S_IDLE  = 7'b0000001,
      S_MAC   = 7'b0000010,
      S_DRAIN = 7'b0000100,
      S_IDX   = 7'b0001000,
      S_LUT   = 7'b0010000,
      S_WB    = 7'b0100000,
      S_START = 7'b1000000
   } state_type;

   // hidden layer widths, deeper layers keep 20 neurons
   function automatic logic [7:0] layer_size(input logic [2:0] layer);
      logic [7:0] size;
      case (layer)
         3'd0:    size = 8'd80;
         3'd1:    size = 8'd65;
         3'd2:    size = 8'd50;
         3'd3:    size = 8'd35;
         3'd4:    size = 8'd20;
         default: size = 8'd20;
      endcase
      return size;
   endfunction

endpackage

/* hw/rtl/msi_req_if.sv */
interface msi_req_if;
   logic        valid;
   logic        ready;
   logic        func;
   logic [14:0] weight_addr;
   logic signed [15:0] weight_value;
   logic [15:0] sample_value;

   modport source(output valid, func, weight_addr, weight_value, sample_value, input ready);
   modport sink(input valid, func, weight_addr, weight_value, sample_value, output ready);
endinterface

/* hw/rtl/msi_rsp_if.sv */
interface msi_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] pred_value;
   logic [4:0]  out_index;
   logic        last;

   modport source(output valid, pred_value, out_index, last, input ready);
   modport sink(input valid, pred_value, out_index, last, output ready);
endinterface

/* hw/rtl/mlp_sigmoid_inference.sv */
// mlp_sigmoid_inference: fixed-point perceptron inference, sigmoid after every layer
// flow: weight writes and non-final samples are taken while idle; the final sample of a
//   vector starts the net, one multiply-accumulate per cycle in the mac state on a single mac unit
//   through the weight memory read port, then per neuron drain, index, table lookup and write-back
// req ready only while idle, so the next vector's samples wait until the net is through
// reset: synchronous, clears sequencer, sample count and result valid; memories keep contents
module mlp_sigmoid_inference
   import msi_pkg::*;
#(
   parameter int IN_COUNT            = 100,
   parameter int OUT_COUNT           = 30,
   parameter int HIDDEN_LAYERS       = 5,
   parameter int WEIGHT_DEPTH        = 32768,
   parameter int SIGMOID_TABLE_DEPTH = 1024
) (
   input logic      clock,
   input logic      reset,
   msi_req_if.sink  req_ch,
   msi_rsp_if.source rsp_ch
);

   localparam int WAW = $clog2(WEIGHT_DEPTH);
   localparam int TIW = $clog2(SIGMOID_TABLE_DEPTH);
   localparam longint Q30 = 64'sd1 << 30;
   localparam longint TD  = longint'(SIGMOID_TABLE_DEPTH);

   // ------------------------------------------------------------------
   // sigmoid table, built at elaboration with integer math only
   // ------------------------------------------------------------------
   logic [15:0] sig_rom [SIGMOID_TABLE_DEPTH];

   for (genvar k = 0; k < SIGMOID_TABLE_DEPTH; k++) begin : g_rom
      localparam longint KK  = longint'(k);
      localparam bit     NEG = (2 * KK < TD);
      localparam longint NN  = NEG ? TD - 2 * KK : 2 * KK - TD;
      // taylor series of e^-u, u = |x|/16, each term truncated
      localparam longint T1  = Q30 * NN / (2 * TD * 1);
      localparam longint T2  = T1 * NN / (2 * TD * 2);
      localparam longint T3  = T2 * NN / (2 * TD * 3);
      localparam longint T4  = T3 * NN / (2 * TD * 4);
      localparam longint T5  = T4 * NN / (2 * TD * 5);
      localparam longint T6  = T5 * NN / (2 * TD * 6);
      localparam longint T7  = T6 * NN / (2 * TD * 7);
      localparam longint T8  = T7 * NN / (2 * TD * 8);
      localparam longint T9  = T8 * NN / (2 * TD * 9);
      localparam longint T10 = T9 * NN / (2 * TD * 10);
      localparam longint T11 = T10 * NN / (2 * TD * 11);
      localparam longint T12 = T11 * NN / (2 * TD * 12);
      localparam longint T13 = T12 * NN / (2 * TD * 13);
      localparam longint T14 = T13 * NN / (2 * TD * 14);
      localparam longint T15 = T14 * NN / (2 * TD * 15);
      localparam longint T16 = T15 * NN / (2 * TD * 16);
      localparam longint T17 = T16 * NN / (2 * TD * 17);
      localparam longint T18 = T17 * NN / (2 * TD * 18);
      localparam longint T19 = T18 * NN / (2 * TD * 19);
      localparam longint T20 = T19 * NN / (2 * TD * 20);
      localparam longint T21 = T20 * NN / (2 * TD * 21);
      localparam longint T22 = T21 * NN / (2 * TD * 22);
      localparam longint T23 = T22 * NN / (2 * TD * 23);
      localparam longint T24 = T23 * NN / (2 * TD * 24);
      localparam longint SUM = Q30 - T1 + T2 - T3 + T4 - T5 + T6 - T7 + T8 - T9 + T10
                               - T11 + T12 - T13 + T14 - T15 + T16 - T17 + T18 - T19
                               + T20 - T21 + T22 - T23 + T24;
      // raise to the 16th power by four squarings
      localparam longint E0  = (SUM > 0) ? SUM : 64'sd0;
      localparam longint E1  = (E0 * E0) >>> 30;
      localparam longint E2  = (E1 * E1) >>> 30;
      localparam longint E3  = (E2 * E2) >>> 30;
      localparam longint E4  = (E3 * E3) >>> 30;
      localparam longint DEN = Q30 + E4;
      localparam longint NUM = NEG ? E4 : Q30;
      localparam longint VAL = ((NUM << 15) + DEN / 2) / DEN;
      assign sig_rom[k] = VAL[15:0];
   end

   // ------------------------------------------------------------------
   // memories: weights, and activations (sample bank plus two hidden banks)
   // ------------------------------------------------------------------
   logic [WEIGHT_W-1:0] wmem [WEIGHT_DEPTH];
   logic [SAMPLE_W-1:0] amem [384];

   logic                wmem_we;
   logic [WAW-1:0]      wmem_wa;
   logic [WAW-1:0]      wmem_ra;
   logic [WEIGHT_W-1:0] w_q_ff;

   logic                amem_we;
   logic [8:0]          amem_wa;
   logic [SAMPLE_W-1:0] amem_wd;
   logic [8:0]          amem_ra;
   logic [SAMPLE_W-1:0] a_q_ff;

   always_ff @(posedge clock) begin
      if (wmem_we) begin
         wmem[wmem_wa] <= req_ch.weight_value;
      end
      w_q_ff <= wmem[wmem_ra];
   end

   always_ff @(posedge clock) begin
      if (amem_we) begin
         amem[amem_wa] <= amem_wd;
      end
      a_q_ff <= amem[amem_ra];
   end

   // ------------------------------------------------------------------
   // sequencer state
   // ------------------------------------------------------------------
   state_type  state_ff, state_in;
   logic [6:0] cnt_ff, cnt_in;           // samples buffered
   logic [3:0] layer_ff, layer_in;       // equals HIDDEN_LAYERS on the output layer
   logic [6:0] nrn_ff, nrn_in;           // neuron within layer
   logic [7:0] j_ff, j_in;               // fan-in position, bias at j == fan
   logic [WAW-1:0] wa_ff, wa_in;         // running weight read address

   logic                 rd_vld_ff, rd_bias_ff;
   logic                 prod_vld_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [ACC_W-1:0]  acc_ff, acc_in;
   logic [43:0]          idxp_ff;
   logic [15:0]          sig_ff;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [15:0]          rsp_pred_ff;
   logic [4:0]           rsp_idx_ff;
   logic                 rsp_last_ff;
   logic                 rsp_load;

   logic       hidden;
   logic [7:0] fan;
   logic [7:0] lsize;
   logic [1:0] src_bank, dst_bank;
   logic       last_nrn;
   logic       req_xfer;
   logic       smp_last;

   assign hidden   = (layer_ff < 4'(HIDDEN_LAYERS));
   assign fan      = (layer_ff == 4'd0) ? 8'(IN_COUNT) : layer_size(3'(layer_ff - 4'd1));
   assign lsize    = hidden ? layer_size(layer_ff[2:0]) : 8'(OUT_COUNT);
   assign src_bank = (layer_ff == 4'd0) ? BANK_SAMPLE :
                     (layer_ff[0] ? BANK_HID_A : BANK_HID_B);
   assign dst_bank = layer_ff[0] ? BANK_HID_B : BANK_HID_A;
   assign last_nrn = ({1'b0, nrn_ff} == lsize - 8'd1);

   assign req_ch.ready = (state_ff == S_IDLE);
   assign req_xfer     = req_ch.valid && req_ch.ready;
   assign smp_last     = ({1'b0, cnt_ff} + 8'd1 == 8'(IN_COUNT));

   // weight writes beyond the memory are dropped
   assign wmem_we = req_xfer && (req_ch.func == FUNC_WEIGHT)
                    && (32'(req_ch.weight_addr) < 32'(WEIGHT_DEPTH));
   assign wmem_wa = WAW'(req_ch.weight_addr);
   assign wmem_ra = wa_ff;
   assign amem_ra = {src_bank, j_ff[6:0]};

   // activation memory write: samples while idle, hidden results at write-back
   always_comb begin
      amem_we = 1'b0;
      amem_wa = {BANK_SAMPLE, cnt_ff};
      amem_wd = req_ch.sample_value;
      if (req_xfer && (req_ch.func == FUNC_SAMPLE)) begin
         amem_we = 1'b1;
      end else if ((state_ff == S_WB) && hidden) begin
         amem_we = 1'b1;
         amem_wa = {dst_bank, nrn_ff};
         amem_wd = {1'b0, sig_ff[15:1]};   // q1.15 to q2.14
      end
   end

   // saturated sum offset into [0, 2^30]
   logic signed [ACC_W-1:0] acc_sat;
   logic [30:0]             acc_off;
   logic [13:0]             idx_raw;
   logic [TIW-1:0]          idx_clamp;

   always_comb begin
      acc_sat = acc_ff;
      if (acc_ff > (ACC_W'(1) <<< 29)) begin
         acc_sat = ACC_W'(1) <<< 29;
      end else if (acc_ff < -(ACC_W'(1) <<< 29)) begin
         acc_sat = -(ACC_W'(1) <<< 29);
      end
      acc_off   = 31'(acc_sat + (ACC_W'(1) <<< 29));
      idx_raw   = idxp_ff[43:30];
      idx_clamp = (idx_raw > 14'(SIGMOID_TABLE_DEPTH - 1)) ?
                  TIW'(SIGMOID_TABLE_DEPTH - 1) : TIW'(idx_raw);
   end

   // mac datapath: read, multiply, accumulate
   logic [SAMPLE_W-1:0] act_op;
   assign act_op = rd_bias_ff ? ONE_Q14 : a_q_ff;

   always_ff @(posedge clock) begin
      prod_ff <= $signed({1'b0, act_op}) * $signed(w_q_ff);
      idxp_ff <= 44'(acc_off) * 44'(SIGMOID_TABLE_DEPTH);
      if (state_ff == S_LUT) begin
         sig_ff <= sig_rom[idx_clamp];
      end
      if (rsp_load) begin
         rsp_pred_ff <= sig_ff;
         rsp_idx_ff  <= nrn_ff[4:0];
         rsp_last_ff <= last_nrn;
      end
   end

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      layer_in     = layer_ff;
      nrn_in       = nrn_ff;
      j_in         = j_ff;
      wa_in        = wa_ff;
      acc_in       = acc_ff;
      rsp_load     = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      if (prod_vld_ff) begin
         acc_in = acc_ff + ACC_W'(prod_ff);
      end
      case (state_ff)
         S_IDLE: begin
            if (req_xfer && (req_ch.func == FUNC_SAMPLE)) begin
               if (smp_last) begin
                  cnt_in   = '0;
                  state_in = S_START;
               end else begin
                  cnt_in = cnt_ff + 7'd1;
               end
            end
         end
         S_START: begin
            layer_in = '0;
            nrn_in   = '0;
            j_in     = '0;
            wa_in    = '0;
            acc_in   = '0;
            state_in = S_MAC;
         end
         S_MAC: begin
            wa_in = (wa_ff == WAW'(WEIGHT_DEPTH - 1)) ? '0 : wa_ff + WAW'(1);
            if (j_ff == fan) begin
               state_in = S_DRAIN;
            end else begin
               j_in = j_ff + 8'd1;
            end
         end
         S_DRAIN: begin
            if (!rd_vld_ff && !prod_vld_ff) begin
               state_in = S_IDX;
            end
         end
         S_IDX: begin
            state_in = S_LUT;
         end
         S_LUT: begin
            state_in = S_WB;
         end
         S_WB: begin
            if (hidden || !rsp_valid_in) begin
               rsp_load = !hidden;
               j_in     = '0;
               acc_in   = '0;
               state_in = S_MAC;
               nrn_in   = nrn_ff + 7'd1;
               if (last_nrn) begin
                  nrn_in   = '0;
                  layer_in = layer_ff + 4'd1;
                  if (!hidden) begin
                     state_in = S_IDLE;
                  end
               end
            end
            if (rsp_load) begin
               rsp_valid_in = 1'b1;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         rd_vld_ff    <= 1'b0;
         prod_vld_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         rd_vld_ff    <= (state_ff == S_MAC);
         prod_vld_ff  <= rd_vld_ff;
      end
      layer_ff   <= layer_in;
      nrn_ff     <= nrn_in;
      j_ff       <= j_in;
      wa_ff      <= wa_in;
      acc_ff     <= acc_in;
      rd_bias_ff <= (j_ff == fan);
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.pred_value = rsp_pred_ff;
   assign rsp_ch.out_index  = rsp_idx_ff;
   assign rsp_ch.last       = rsp_last_ff;

   // ------------------------------------------------------------------
   // assertions
   // ------------------------------------------------------------------
   a_start: assert property (@(posedge clock) disable iff (reset)
      req_xfer && (req_ch.func == FUNC_SAMPLE) && smp_last |=> state_ff == S_START)
      else $error("final sample did not start the net");

   a_no_wr_busy: assert property (@(posedge clock) disable iff (reset)
      state_ff != S_IDLE |-> !wmem_we)
      else $error("weight write while computing");

   a_hid_bank: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WB) && hidden |-> amem_wa[8:7] != BANK_SAMPLE)
      else $error("hidden write into sample bank");

   a_last_idx: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_last_ff |-> rsp_idx_ff == 5'(OUT_COUNT - 1))
      else $error("last flag on wrong output");

   a_drain: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_IDX |-> !rd_vld_ff && !prod_vld_ff)
      else $error("sum taken with mac pipeline busy");

endmodule

/* verif/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;
   import msi_pkg::*;

   localparam int  MEM_WORDS   = 32768;
   localparam int  LUT_WORDS   = 1024;
   localparam int  VEC_LEN     = 100;
   localparam int  NUM_OUTS    = 30;
   localparam int  CYCLE_LIMIT = 1000000;
   // total words the net actually reads
   localparam int  USED_WORDS  = 19780;

   typedef struct {
      logic        func;
      logic [14:0] addr;
      logic [15:0] wval;
      logic [15:0] sval;
   } req_item_type;

   typedef struct {
      logic [15:0] pred;
      logic [4:0]  idx;
      logic        last;
   } pred_item_type;

   logic clock;
   logic reset;

   msi_req_if req_bus();
   msi_rsp_if rsp_bus();

   mlp_sigmoid_inference dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus)
   );

   // pending stimulus and predicted outputs
   req_item_type  pending_reqs[$];
   pred_item_type expected_preds[$];

   // predictor state
   logic [15:0] weight_mem [0:MEM_WORDS-1];
   logic [15:0] sample_buf [0:127];
   logic [15:0] cur_act    [0:127];
   logic [15:0] next_act   [0:127];
   logic [15:0] sig_lut    [0:LUT_WORDS-1];
   int          sample_cnt;
   int          hid_width  [0:4] = '{80, 65, 50, 35, 20};

   int  errors;
   int  cycle_cnt;
   int  weight_xfers;
   int  sample_xfers;
   int  pred_xfers;
   bit  req_taken;

   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   task automatic flag_mismatch(input string msg);
      $display("MISMATCH at cycle %0d: %s", cycle_cnt, msg);
      errors++;
   endtask

   // one sigmoid table entry, integer only: taylor e^-u, square four times
   function automatic logic [15:0] sigmoid_entry(input int k);
      longint unsigned depth, n, term, e, den, num, i;
      longint          acc;
      bit              neg;
      depth = LUT_WORDS;
      n     = (2 * k >= LUT_WORDS) ? 2 * k - depth : depth - 2 * k;
      neg   = (2 * k < LUT_WORDS);
      acc   = longint'(64'd1 << 30);
      term  = 64'd1 << 30;
      for (i = 1; i <= 24; i++) begin
         term = term * n / (2 * depth * i);
         if (i[0])
            acc -= longint'(term);
         else
            acc += longint'(term);
      end
      e = (acc > 0) ? longint'(acc) : 0;
      for (i = 0; i < 4; i++)
         e = (e * e) >> 30;
      den = (64'd1 << 30) + e;
      num = neg ? e : (64'd1 << 30);
      return 16'((((num << 15) + den / 2) / den));
   endfunction

   // one neuron over cur_act, bias weight after the fan-in weights
   function automatic logic [15:0] neuron_out(input int fan, input int base);
      longint acc;
      longint idx;
      int     j;
      acc = 0;
      for (j = 0; j < fan; j++)
         acc += longint'(cur_act[j]) * longint'($signed(weight_mem[(base + j) % MEM_WORDS]));
      acc += 64'sd16384 * longint'($signed(weight_mem[(base + fan) % MEM_WORDS]));
      if (acc > (64'sd1 <<< 29))
         acc = 64'sd1 <<< 29;
      if (acc < -(64'sd1 <<< 29))
         acc = -(64'sd1 <<< 29);
      idx = (acc + (64'sd1 <<< 29)) >>> 20;
      if (idx > LUT_WORDS - 1)
         idx = LUT_WORDS - 1;
      return sig_lut[idx];
   endfunction

   // full forward pass once a vector is complete
   task automatic forward_pass();
      int fan, base, l, n;
      pred_item_type p;
      for (n = 0; n < 128; n++)
         cur_act[n] = sample_buf[n];
      fan  = VEC_LEN;
      base = 0;
      for (l = 0; l < 5; l++) begin
         for (n = 0; n < hid_width[l]; n++)
            next_act[n] = neuron_out(fan, base + n * (fan + 1)) >> 1;
         base += hid_width[l] * (fan + 1);
         for (n = 0; n < 128; n++)
            cur_act[n] = next_act[n];
         fan = hid_width[l];
      end
      for (n = 0; n < NUM_OUTS; n++) begin
         p.pred = neuron_out(fan, base + n * (fan + 1));
         p.idx  = 5'(n);
         p.last = (n == NUM_OUTS - 1);
         expected_preds.push_back(p);
      end
   endtask

   // update predictor for one accepted request
   task automatic apply_request(input req_item_type it);
      if (it.func == FUNC_WEIGHT) begin
         weight_mem[it.addr] = it.wval;
         weight_xfers++;
      end else begin
         sample_buf[sample_cnt] = it.sval;
         sample_cnt++;
         sample_xfers++;
         if (sample_cnt == VEC_LEN) begin
            sample_cnt = 0;
            forward_pass();
         end
      end
   endtask

   function automatic req_item_type mk_weight(input int addr, input int val);
      req_item_type it;
      it.func = FUNC_WEIGHT;
      it.addr = 15'(addr);
      it.wval = 16'(val);
      it.sval = 16'($urandom);
      return it;
   endfunction

   function automatic req_item_type mk_sample(input int val);
      req_item_type it;
      it.func = FUNC_SAMPLE;
      it.addr = 15'($urandom);
      it.wval = 16'($urandom);
      it.sval = 16'(val);
      return it;
   endfunction

   // mostly modest weights so outputs land inside the table, some full scale
   function automatic int rand_weight();
      int r;
      r = $urandom_range(0, 99);
      if (r < 85)
         return $urandom_range(0, 1200) - 600;
      else if (r < 95)
         return $urandom_range(0, 65535) - 32768;
      else
         return (r < 97) ? -32768 : 32767;
   endfunction

   function automatic int rand_sample();
      int r;
      r = $urandom_range(0, 7);
      if (r == 0)
         return 0;
      else if (r == 1)
         return 65535;
      else
         return $urandom_range(0, 65535);
   endfunction

   // no idling at all inside this window
   function automatic bit calm_window();
      return (cycle_cnt >= 30000 && cycle_cnt < 50000);
   endfunction

   // request driver: change at falling edge, a transfer retires the current item
   always @(negedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else if (!req_bus.valid || req_taken) begin
         if (pending_reqs.size() > 0 && (calm_window() || $urandom_range(0, 99) >= 6)) begin
            req_item_type it;
            it = pending_reqs.pop_front();
            req_bus.func         <= it.func;
            req_bus.weight_addr  <= it.addr;
            req_bus.weight_value <= it.wval;
            req_bus.sample_value <= it.sval;
            req_bus.valid        <= 1'b1;
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // receiver stalls at random
   always @(negedge clock) begin
      if (reset)
         rsp_bus.ready <= 1'b0;
      else
         rsp_bus.ready <= calm_window() || ($urandom_range(0, 99) >= 6);
   end

   // request transfer: feed predictor with what was on the bus
   always @(posedge clock) begin
      req_taken = 1'b0;
      if (!reset && req_bus.valid && req_bus.ready) begin
         req_item_type it;
         it.func = req_bus.func;
         it.addr = req_bus.weight_addr;
         it.wval = req_bus.weight_value;
         it.sval = req_bus.sample_value;
         apply_request(it);
         req_taken = 1'b1;
      end
   end

   // result monitor, compared against the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         pred_xfers++;
         if (expected_preds.size() == 0) begin
            flag_mismatch($sformatf("unexpected output idx %0d value %0d",
                                    rsp_bus.out_index, rsp_bus.pred_value));
         end else begin
            pred_item_type p;
            p = expected_preds.pop_front();
            if (rsp_bus.pred_value !== p.pred)
               flag_mismatch($sformatf("pred_value idx %0d: got %0d want %0d",
                                       p.idx, rsp_bus.pred_value, p.pred));
            if (rsp_bus.out_index !== p.idx)
               flag_mismatch($sformatf("out_index: got %0d want %0d",
                                       rsp_bus.out_index, p.idx));
            if (rsp_bus.last !== p.last)
               flag_mismatch($sformatf("last idx %0d: got %0b want %0b",
                                       p.idx, rsp_bus.last, p.last));
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_cnt++;
      if (cycle_cnt >= CYCLE_LIMIT) begin
         $display("timeout with %0d outputs still expected", expected_preds.size());
         $display("mlp_sigmoid_inference verification failed");
         $finish;
      end
   end

   initial begin
      int i;
      req_bus.valid        = 1'b0;
      req_bus.func         = FUNC_WEIGHT;
      req_bus.weight_addr  = '0;
      req_bus.weight_value = '0;
      req_bus.sample_value = '0;
      rsp_bus.ready        = 1'b0;
      reset      = 1'b1;
      errors     = 0;
      cycle_cnt  = 0;
      sample_cnt = 0;
      req_taken  = 1'b0;

      for (i = 0; i < LUT_WORDS; i++)
         sig_lut[i] = sigmoid_entry(i);

      // weight preload covering every word the net reads
      for (i = 0; i < USED_WORDS; i++)
         pending_reqs.push_back(mk_weight(i, rand_weight()));

      // directed: extreme values and addresses, writes inside a partial vector
      pending_reqs.push_back(mk_weight(32767, -32768));
      pending_reqs.push_back(mk_weight(32766, 32767));
      pending_reqs.push_back(mk_weight(16384, 0));
      pending_reqs.push_back(mk_sample(0));
      pending_reqs.push_back(mk_sample(65535));
      pending_reqs.push_back(mk_weight(0, 32767));
      pending_reqs.push_back(mk_weight(100, -32768));
      pending_reqs.push_back(mk_sample(16384));
      pending_reqs.push_back(mk_weight(USED_WORDS - 1, -32768));
      pending_reqs.push_back(mk_weight(USED_WORDS - 2, 32767));
      pending_reqs.push_back(mk_sample(65535));
      pending_reqs.push_back(mk_sample(0));

      // random: mostly samples, some weight rewrites anywhere in memory
      for (i = 0; i < 370; i++) begin
         if ($urandom_range(0, 99) < 85)
            pending_reqs.push_back(mk_sample(rand_sample()));
         else if ($urandom_range(0, 1))
            pending_reqs.push_back(mk_weight($urandom_range(0, USED_WORDS - 1), rand_weight()));
         else
            pending_reqs.push_back(mk_weight($urandom_range(0, 32767),
                                             $urandom_range(0, 65535) - 32768));
      end

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // drain: all requests out, all predictions matched
      while (pending_reqs.size() > 0 || req_bus.valid || expected_preds.size() > 0)
         @(posedge clock);
      repeat (200) @(posedge clock);
      if (expected_preds.size() > 0)
         flag_mismatch($sformatf("%0d outputs never arrived", expected_preds.size()));

      $display("covered %0d weight writes, %0d samples, %0d outputs checked",
               weight_xfers, sample_xfers, pred_xfers);
      $display("%0d mismatches in %0d cycles", errors, cycle_cnt);
      if (errors == 0)
         $display("mlp_sigmoid_inference verification clean");
      else
         $display("mlp_sigmoid_inference verification failed");
      $finish;
   end

endmodule
